FILE: rtl/core/i2rd_pkg.sv
// Shared constants and helpers for the integer to radix digit converter.
package i2rd_pkg;

  localparam int unsigned ValueBits  = 31;
  localparam int unsigned RadixBits  = 6;
  localparam int unsigned DigitBits  = 6;
  localparam int unsigned CharBits   = 7;
  localparam int unsigned RecipBits  = 32;
  localparam int unsigned StoreDepth = ValueBits + 1;
  localparam int unsigned PtrBits    = $clog2(StoreDepth);
  localparam int unsigned ProdBits   = ValueBits + RecipBits;
  // residue after the estimate is below twice the radix, so a few low bits suffice
  localparam int unsigned RemBits    = RadixBits + 1;

  localparam logic [RadixBits-1:0] RadixMin     = RadixBits'(2);
  localparam logic [RadixBits-1:0] RadixMax     = RadixBits'(36);
  localparam logic [DigitBits-1:0] DecimalLimit = DigitBits'(10);
  localparam logic [CharBits-1:0]  AsciiZero    = CharBits'(8'h30);
  localparam logic [CharBits-1:0]  AsciiAlpha   = CharBits'(8'h41);

  function automatic logic [RadixBits-1:0] clamp_radix(input logic [RadixBits-1:0] r);
    logic [RadixBits-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

  // floor(2^32 / r) for r in 2..36
  function automatic logic [RecipBits-1:0] recip(input logic [RadixBits-1:0] r);
    logic [RecipBits-1:0] res;
    unique case (r)
      6'd2:    res = 32'd2147483648;
      6'd3:    res = 32'd1431655765;
      6'd4:    res = 32'd1073741824;
      6'd5:    res = 32'd858993459;
      6'd6:    res = 32'd715827882;
      6'd7:    res = 32'd613566756;
      6'd8:    res = 32'd536870912;
      6'd9:    res = 32'd477218588;
      6'd10:   res = 32'd429496729;
      6'd11:   res = 32'd390451572;
      6'd12:   res = 32'd357913941;
      6'd13:   res = 32'd330382099;
      6'd14:   res = 32'd306783378;
      6'd15:   res = 32'd286331153;
      6'd16:   res = 32'd268435456;
      6'd17:   res = 32'd252645135;
      6'd18:   res = 32'd238609294;
      6'd19:   res = 32'd226050910;
      6'd20:   res = 32'd214748364;
      6'd21:   res = 32'd204522252;
      6'd22:   res = 32'd195225786;
      6'd23:   res = 32'd186737708;
      6'd24:   res = 32'd178956970;
      6'd25:   res = 32'd171798691;
      6'd26:   res = 32'd165191049;
      6'd27:   res = 32'd159072862;
      6'd28:   res = 32'd153391689;
      6'd29:   res = 32'd148102320;
      6'd30:   res = 32'd143165576;
      6'd31:   res = 32'd138547332;
      6'd32:   res = 32'd134217728;
      6'd33:   res = 32'd130150524;
      6'd34:   res = 32'd126322567;
      6'd35:   res = 32'd122713351;
      6'd36:   res = 32'd119304647;
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [CharBits-1:0] digit_to_ascii(input logic [DigitBits-1:0] d);
    logic [CharBits-1:0] res;
    if (d < DecimalLimit) res = AsciiZero + CharBits'(d);
    else res = AsciiAlpha + CharBits'(d - DecimalLimit);
    return res;
  endfunction

endpackage

FILE: rtl/core/i2rd_in_if.sv
// Input channel: integer and radix with valid/ready handshake.
interface i2rd_in_if;
  logic                               valid;
  logic                               ready;
  logic [i2rd_pkg::ValueBits-1:0]     value;
  logic [i2rd_pkg::RadixBits-1:0]     radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

FILE: rtl/core/i2rd_out_if.sv
// Output channel: one ASCII digit per transfer with a last flag.
interface i2rd_out_if;
  logic                              valid;
  logic                              ready;
  logic [i2rd_pkg::CharBits-1:0]     digit_char;
  logic                              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

FILE: rtl/core/integer_to_radix_digits_top.sv
// Integer to radix digit converter: sequencer, shared multiplier and digit store.
//
// Usage:
//   in_i  : one transfer carries a 31-bit unsigned value and a 6-bit radix.
//           Radix below 2 is taken as 2, above 36 as 36.
//   out_o : one transfer per digit, most significant first, as ASCII
//           '0'-'9' / 'A'-'Z'; last is high on the final digit. Zero gives '0'.
// Sequence:
//   Each division step runs on the one shared multiplier through StMul,
//   StSub and StCor (reciprocal multiply, back-multiply, correction). Once
//   converted, each digit is emitted through StRead, StLoad and StHold
//   (read, load, transfer). One item at a time: in_i.ready is high only
//   while idle, so no new item is taken until its last digit is out.
// Reset: asynchronous, active low; returns to idle with no digit pending.
// Stall: a held digit stays in the output register until taken; the
//   sequencer waits and nothing is lost or repeated.
module integer_to_radix_digits_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  i2rd_in_if.sink        in_i,
  i2rd_out_if.source     out_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,    // quotient times reciprocal, or finish if single digit left
    StSub,    // residue = quotient - estimate * radix
    StCor,    // fix estimate by at most one, store digit
    StRead,   // memory read in flight
    StLoad,   // move read digit into output register
    StHold    // wait for output transfer
  } state_e;

  state_e state_q;

  logic [i2rd_pkg::ValueBits-1:0] quot_q;
  logic [i2rd_pkg::ValueBits-1:0] qest_q;
  logic [i2rd_pkg::RadixBits-1:0] radix_q;
  logic [i2rd_pkg::RemBits-1:0]   rem_q;
  logic [i2rd_pkg::PtrBits-1:0]   ptr_q;
  logic                           out_valid_q;
  logic [i2rd_pkg::CharBits-1:0]  out_char_q;
  logic                           out_last_q;

  // digit store
  logic [i2rd_pkg::DigitBits-1:0] mem_q [i2rd_pkg::StoreDepth];
  logic [i2rd_pkg::DigitBits-1:0] rd_data_q;
  logic                           wr_en;
  logic [i2rd_pkg::DigitBits-1:0] wr_data;

  // arithmetic: one multiplier, operands steered by state
  logic [i2rd_pkg::ValueBits-1:0] mul_a;
  logic [i2rd_pkg::RecipBits-1:0] mul_b;
  logic [i2rd_pkg::ProdBits-1:0]  mul_p;
  logic [i2rd_pkg::RemBits-1:0]   radix_ext;
  logic                           rem_over;
  logic                           single_left;

  always_comb begin
    if (state_q == StMul) begin
      mul_a = quot_q;
      mul_b = i2rd_pkg::recip(radix_q);
    end else begin
      mul_a = qest_q;
      mul_b = i2rd_pkg::RecipBits'(radix_q);
    end
  end

  assign mul_p       = mul_a * mul_b;
  assign radix_ext   = {1'b0, radix_q};
  assign rem_over    = (rem_q >= radix_ext);
  assign single_left = (quot_q < i2rd_pkg::ValueBits'(radix_q)) ||
                       (ptr_q == i2rd_pkg::PtrBits'(i2rd_pkg::StoreDepth - 1));

  always_comb begin
    wr_en   = 1'b0;
    wr_data = quot_q[i2rd_pkg::DigitBits-1:0];
    if (state_q == StCor) begin
      wr_en   = 1'b1;
      wr_data = rem_over ? i2rd_pkg::DigitBits'(rem_q - radix_ext)
                         : rem_q[i2rd_pkg::DigitBits-1:0];
    end else if (state_q == StMul && single_left) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ptr_q] <= wr_data;
    end
    rd_data_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      quot_q      <= '0;
      qest_q      <= '0;
      radix_q     <= '0;
      rem_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            quot_q  <= in_i.value;
            radix_q <= i2rd_pkg::clamp_radix(in_i.radix);
            ptr_q   <= '0;
            state_q <= StMul;
          end
        end
        StMul: begin
          if (single_left) begin
            // final (most significant) digit written; ptr now addresses it
            quot_q  <= '0;
            state_q <= StRead;
          end else begin
            qest_q  <= mul_p[i2rd_pkg::ProdBits-1 -: i2rd_pkg::ValueBits];
            state_q <= StSub;
          end
        end
        StSub: begin
          rem_q   <= quot_q[i2rd_pkg::RemBits-1:0] - mul_p[i2rd_pkg::RemBits-1:0];
          state_q <= StCor;
        end
        StCor: begin
          quot_q  <= rem_over ? qest_q + i2rd_pkg::ValueBits'(1) : qest_q;
          ptr_q   <= ptr_q + i2rd_pkg::PtrBits'(1);
          state_q <= StMul;
        end
        StRead: begin
          state_q <= StLoad;
        end
        StLoad: begin
          out_char_q  <= i2rd_pkg::digit_to_ascii(rd_data_q);
          out_last_q  <= (ptr_q == '0);
          out_valid_q <= 1'b1;
          state_q     <= StHold;
        end
        StHold: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= StIdle;
            end else begin
              ptr_q   <= ptr_q - i2rd_pkg::PtrBits'(1);
              state_q <= StRead;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_i.ready       = (state_q == StIdle);
  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last       = out_last_q;

endmodule
